@@ hdl/mfps_pkg.sv @@
package mfps_pkg;

  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 9;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  localparam int FIFO_DEPTH = 2;

  // Position class of one cell, worked out by the front end.
  typedef struct packed {
    logic first_row;
    logic left_ok;
    logic right_ok;
    logic last_row;
    logic grid_end;
  } mfps_flags_t;

  typedef struct packed {
    logic x_busy;
    logic grid_fire;
  } mfps_bk_stat_t;

endpackage

@@ hdl/mfps_if.sv @@
interface mfps_in_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface mfps_out_if #(
  parameter int OUT_BITS = 26
) ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] path_max;

  modport source (output valid, output path_max, input ready);
  modport sink   (input valid, input path_max, output ready);
endinterface

@@ hdl/mfps_fifo.sv @@
module mfps_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 push_data,
  input  logic                         pop,
  output logic [W-1:0]                 pop_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;

  assign full     = (cnt_r == CNTW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/mfps_front.sv @@
module mfps_front #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 16,
  parameter int CW         = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mfps_in_if.sink                             in_ch,
  input  logic                                cfg_we,
  input  logic [mfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output logic signed [VALUE_BITS-1:0]        q_value,
  output logic [CW-1:0]                       q_col,
  output mfps_pkg::mfps_flags_t               q_flags
);
  import mfps_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROWS_W-1:0] num_rows_r;
  logic [COLS_W-1:0] num_cols_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;

  logic [31:0] rows_eff;
  logic [31:0] cols_eff;
  logic [31:0] col_inc;
  logic [31:0] row_inc;
  logic        last_col;
  logic        last_row;

  always_comb begin
    if (num_rows_r == '0) begin
      rows_eff = 32'd1;
    end else if (32'(num_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end else begin
      rows_eff = 32'(num_rows_r);
    end
    if (num_cols_r == '0) begin
      cols_eff = 32'd1;
    end else if (32'(num_cols_r) > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = 32'(num_cols_r);
    end
    col_inc  = 32'(col_r) + 32'd1;
    row_inc  = 32'(row_r) + 32'd1;
    last_col = (col_inc >= cols_eff);
    last_row = (row_inc >= rows_eff);

    q_flags.first_row = (row_r == '0);
    q_flags.left_ok   = (col_r != '0);
    q_flags.right_ok  = !last_col;
    q_flags.last_row  = last_row;
    q_flags.grid_end  = last_col && last_row;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_value     = in_ch.cell_value;
  assign q_col       = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ROWS_W'(1);
      num_cols_r <= COLS_W'(1);
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS: num_rows_r <= cfg_data[ROWS_W-1:0];
          REG_NUM_COLS: num_cols_r <= cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

endmodule

@@ hdl/mfps_back.sv @@
module mfps_back #(
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 16,
  parameter int SUM_W      = 27,
  parameter int CW         = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic signed [VALUE_BITS-1:0]  q_value,
  input  logic [CW-1:0]                 q_col,
  input  mfps_pkg::mfps_flags_t         q_flags,
  output logic                          q_pop,
  mfps_out_if.source                    out_ch,
  output mfps_pkg::mfps_bk_stat_t       stat
);
  import mfps_pkg::*;

  localparam int OUT_W = SUM_W - 1;
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Row store: best sums of the row above, overwritten column by column.
  logic signed [SUM_W-1:0] row_mem [MAX_COLS];

  logic                         x_vld_r;
  logic signed [VALUE_BITS-1:0] x_val_r;
  logic [CW-1:0]                x_col_r;
  mfps_flags_t                  x_flags_r;
  logic signed [SUM_W-1:0]      rd0_r;
  logic signed [SUM_W-1:0]      rd1_r;
  logic                         fwd_vld_r;
  logic [CW-1:0]                fwd_addr_r;
  logic signed [SUM_W-1:0]      fwd_data_r;
  logic signed [SUM_W-1:0]      left_prev_r;
  logic signed [SUM_W-1:0]      final_max_r;
  logic signed [SUM_W-1:0]      final_max_nxt;
  logic                         out_valid_r;
  logic signed [OUT_W-1:0]      out_data_r;

  logic                    x_adv;
  logic                    x_fire;
  logic [CW-1:0]           q_col_p1;
  logic [CW-1:0]           x_col_p1;
  logic signed [SUM_W-1:0] v_ext;
  logic signed [SUM_W-1:0] op_c;
  logic signed [SUM_W-1:0] op_n;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W-1:0] sum;

  assign x_adv    = !x_flags_r.grid_end || !out_valid_r || out_ch.ready;
  assign x_fire   = x_vld_r && x_adv;
  assign q_pop    = !q_empty && (!x_vld_r || x_adv);
  assign q_col_p1 = q_col + CW'(1);
  assign x_col_p1 = x_col_r + CW'(1);

  always_comb begin
    v_ext = {{(SUM_W-VALUE_BITS){x_val_r[VALUE_BITS-1]}}, x_val_r};
    // Take the write that landed in the same cycle as the store read.
    op_c = (fwd_vld_r && fwd_addr_r == x_col_r)  ? fwd_data_r : rd0_r;
    op_n = (fwd_vld_r && fwd_addr_r == x_col_p1) ? fwd_data_r : rd1_r;
    best = op_c;
    if (x_flags_r.left_ok && left_prev_r > best) begin
      best = left_prev_r;
    end
    if (x_flags_r.right_ok && op_n > best) begin
      best = op_n;
    end
    sum = x_flags_r.first_row ? v_ext : v_ext + best;
    final_max_nxt = (x_flags_r.last_row && sum > final_max_r) ? sum : final_max_r;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.path_max = out_data_r;
  assign stat.x_busy     = x_vld_r;
  assign stat.grid_fire  = x_fire && x_flags_r.grid_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      left_prev_r <= '0;
      final_max_r <= SUM_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        x_vld_r   <= 1'b1;
        fwd_vld_r <= x_fire;
      end else if (x_fire) begin
        x_vld_r <= 1'b0;
      end
      if (x_fire) begin
        left_prev_r <= op_c;
        final_max_r <= x_flags_r.grid_end ? SUM_MIN : final_max_nxt;
      end
      if (x_fire && x_flags_r.grid_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      row_mem[x_col_r] <= sum;
    end
    if (q_pop) begin
      rd0_r      <= row_mem[q_col];
      rd1_r      <= row_mem[q_col_p1];
      x_val_r    <= q_value;
      x_col_r    <= q_col;
      x_flags_r  <= q_flags;
      fwd_addr_r <= x_col_r;
      fwd_data_r <= sum;
    end
    if (x_fire && x_flags_r.grid_end) begin
      out_data_r <= final_max_nxt[OUT_W-1:0];
    end
  end

endmodule

@@ hdl/max_falling_path_sum.sv @@
// Maximum falling path sum over a grid streamed in row-major order.
// Throughput: one cell per cycle unless the result output stalls, set by the add-max
// in the back end and the registered two-port read of the row store ahead of it.
// Result: path_max is registered when the back end fires the grid's last cell.
// Reset: num_rows and num_cols return to 1, position and queue clear, running
// maximum goes to the most negative value; the row store is not cleared.
module max_falling_path_sum #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mfps_in_if.sink                         in_ch,
  mfps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfps_pkg::*;

  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SUM_W  = VALUE_BITS + $clog2(MAX_ROWS) + 1;
  localparam int FLAG_W = $bits(mfps_flags_t);
  localparam int ITEM_W = FLAG_W + CW + VALUE_BITS;
  localparam int CNTW   = $clog2(FIFO_DEPTH + 1);

  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [CNTW-1:0]              q_cnt;
  logic signed [VALUE_BITS-1:0] fr_value;
  logic [CW-1:0]                fr_col;
  mfps_flags_t                  fr_flags;
  logic [ITEM_W-1:0]            q_wdata;
  logic [ITEM_W-1:0]            q_rdata;
  logic signed [VALUE_BITS-1:0] bk_value;
  logic [CW-1:0]                bk_col;
  mfps_flags_t                  bk_flags;
  mfps_bk_stat_t                bk_stat;

  mfps_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS),
    .CW         (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_value   (fr_value),
    .q_col     (fr_col),
    .q_flags   (fr_flags)
  );

  assign q_wdata = {fr_flags, fr_col, fr_value};

  mfps_fifo #(
    .W     (ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty),
    .count     (q_cnt)
  );

  assign bk_flags = q_rdata[ITEM_W-1 -: FLAG_W];
  assign bk_col   = q_rdata[VALUE_BITS +: CW];
  assign bk_value = q_rdata[VALUE_BITS-1:0];

  mfps_back #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS),
    .SUM_W      (SUM_W),
    .CW         (CW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_value (bk_value),
    .q_col   (bk_col),
    .q_flags (bk_flags),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (bk_stat)
  );

  a_result_after_grid_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(bk_stat.grid_fire))
    else $error("result raised without a grid end");

  a_request_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (q_cnt != '0))
    else $error("accepted request missing from queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CNTW'(FIFO_DEPTH))
    else $error("queue count past depth");

  a_back_pulls: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !bk_stat.x_busy) |=> bk_stat.x_busy)
    else $error("back end idle with work queued");

endmodule
